// ===== design/hvd_pkg.sv =====
// ----------------------------------------------------------------------------
// hvd_pkg
// Types and constants shared by the horseshoe vortex downwash pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

  // Differences of two 32-bit coordinates never wrap in 33 bits.
  localparam int DIFF_W  = 33;
  localparam int SQ_W    = 2 * DIFF_W;
  // Radicand padded to an even width; one root bit per pipeline stage.
  localparam int RAD_W   = 70;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int RATIO_W = 30;
  localparam int NUM_W   = 31;
  localparam int INV_W   = 29;
  // 1 / (4 pi) in Q0.32.
  localparam logic [INV_W-1:0] INV_4PI = 29'd341782638;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [DIFF_W-1:0] mag_t;

  typedef struct packed {
    diff_t dx;
    diff_t dl;
    diff_t dr;
    diff_t dlm;
    diff_t drm;
  } diffs_t;

  typedef struct packed {
    logic neg_dx;
    logic neg_dl;
    logic neg_dr;
    logic neg_dlm;
    logic neg_drm;
    mag_t mag_dx;
    mag_t mag_dl;
    mag_t mag_dr;
    mag_t mag_dlm;
    mag_t mag_drm;
  } side_t;

  typedef struct packed {
    logic [5:0] neg;
    logic [5:0] zero;
  } term_flag_t;

  function automatic mag_t mag_of(input diff_t v);
    mag_of = v[DIFF_W-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage

// ===== design/hvd_delay.sv =====
// ----------------------------------------------------------------------------
// hvd_delay
// Payload delay line that keeps side data level with a pipelined unit.
// ----------------------------------------------------------------------------
module hvd_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ===== design/hvd_sqrt.sv =====
// ----------------------------------------------------------------------------
// hvd_sqrt
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage.
// ----------------------------------------------------------------------------
module hvd_sqrt #(
  parameter int RAD_W = 70
) (
  input  logic               clk,
  input  logic               en,
  input  logic [RAD_W-1:0]   rad,
  output logic [RAD_W/2-1:0] root
);

  localparam int N  = RAD_W / 2;
  localparam int RW = N + 2;

  logic [RW-1:0]    rem_r  [N];
  logic [N-1:0]     root_r [N];
  logic [RAD_W-1:0] rad_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0]    rem_p;
    logic [RW-1:0]    cur;
    logic [RW-1:0]    trial;
    logic [N-1:0]     root_p;
    logic [RAD_W-1:0] rad_p;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
    end

    // Bring down the next two radicand bits and try a one in this root bit.
    assign cur   = {rem_p[RW-3:0], rad_p[RAD_W-1 -: 2]};
    assign trial = {root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[k]  <= cur - trial;
          root_r[k] <= {root_p[N-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cur;
          root_r[k] <= {root_p[N-2:0], 1'b0};
        end
        rad_r[k] <= rad_p << 2;
      end
    end
  end

  assign root = root_r[N-1];

endmodule

// ===== design/hvd_div.sv =====
// ----------------------------------------------------------------------------
// hvd_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor.
// ----------------------------------------------------------------------------
module hvd_div #(
  parameter int DS_W = 35,
  parameter int Q_W  = 30
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DS_W-1:0] rem_in,
  input  logic [Q_W-1:0]  dvd_in,
  input  logic [DS_W-1:0] den_in,
  output logic [Q_W-1:0]  quo
);

  logic [DS_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]  sh_r  [Q_W];
  logic [DS_W-1:0] den_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DS_W-1:0] rem_p;
    logic [Q_W-1:0]  sh_p;
    logic [DS_W-1:0] den_p;
    logic [DS_W:0]   cur;
    logic            fits;

    if (k == 0) begin : g_first
      assign rem_p = rem_in;
      assign sh_p  = dvd_in;
      assign den_p = den_in;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign sh_p  = sh_r[k-1];
      assign den_p = den_r[k-1];
    end

    // The shift register feeds dividend bits out of the top and takes
    // quotient bits in at the bottom.
    assign cur  = {rem_p, sh_p[Q_W-1]};
    assign fits = cur >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fits ? DS_W'(cur - {1'b0, den_p}) : DS_W'(cur);
        sh_r[k]  <= {sh_p[Q_W-2:0], fits};
        den_r[k] <= den_p;
      end
    end
  end

  assign quo = sh_r[Q_W-1];

endmodule

// ===== design/horseshoe_vortex_downwash_top.sv =====
// ----------------------------------------------------------------------------
// horseshoe_vortex_downwash_top
// Biot-Savart downwash of a unit horseshoe vortex and of its mirror image.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output side is ready and
// returns one result per input. Its pipeline contains the bit-per-stage square
// root (35 stages), the ratio dividers (30 stages) and the term dividers
// (2 * FRAC_BITS - 2 stages). The whole pipeline holds while a result waits at
// the output, so nothing is lost, and it sustains one transaction per cycle
// when the output side is ready.
module horseshoe_vortex_downwash_top
  import hvd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_x, point_y, bound_x, left_edge_y, right_edge_y
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // downwash, symmetric_downwash
  output logic [63:0]  m_tdata
);

  localparam int PW    = 2 * FRAC_BITS - 2;
  localparam int SHIFT = 62 - 2 * FRAC_BITS;
  localparam int SW    = PW + 3;
  localparam int EW    = (SW + 1 > 33) ? SW + 1 : 33;
  localparam int LAT   = 73 + PW;
  localparam logic signed [EW-1:0] SAT_HI = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] SAT_LO = EW'(-64'sd2147483648);
  localparam logic [RATIO_W:0] ONE_Q30 = {1'b1, {RATIO_W{1'b0}}};

  logic           en;
  logic [LAT-1:0] vline;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vline[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else if (en) begin
      vline <= {vline[LAT-2:0], s_tvalid};
    end
  end

  // Stage 1: coordinate differences, the mirror edges folded in.
  diffs_t d1, d2, d3, d4;
  logic signed [31:0] px, py, bx, yl, yr;

  assign px = s_tdata[31:0];
  assign py = s_tdata[63:32];
  assign bx = s_tdata[95:64];
  assign yl = s_tdata[127:96];
  assign yr = s_tdata[159:128];

  always_ff @(posedge clk) begin
    if (en) begin
      d1.dx  <= DIFF_W'(px) - DIFF_W'(bx);
      d1.dl  <= DIFF_W'(py) - DIFF_W'(yl);
      d1.dr  <= DIFF_W'(py) - DIFF_W'(yr);
      d1.dlm <= DIFF_W'(py) + DIFF_W'(yr);
      d1.drm <= DIFF_W'(py) + DIFF_W'(yl);
    end
  end

  // Stage 2: squares.
  logic [SQ_W-1:0] sq_dx, sq_dl, sq_dr, sq_dlm, sq_drm;
  mag_t m1_dx, m1_dl, m1_dr, m1_dlm, m1_drm;

  assign m1_dx  = mag_of(d1.dx);
  assign m1_dl  = mag_of(d1.dl);
  assign m1_dr  = mag_of(d1.dr);
  assign m1_dlm = mag_of(d1.dlm);
  assign m1_drm = mag_of(d1.drm);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_dx  <= m1_dx * m1_dx;
      sq_dl  <= m1_dl * m1_dl;
      sq_dr  <= m1_dr * m1_dr;
      sq_dlm <= m1_dlm * m1_dlm;
      sq_drm <= m1_drm * m1_drm;
      d2     <= d1;
    end
  end

  // Stage 3: radicands of the four distances.
  logic [RAD_W-1:0] rad [4];

  always_ff @(posedge clk) begin
    if (en) begin
      rad[0] <= RAD_W'(sq_dx) + RAD_W'(sq_dl);
      rad[1] <= RAD_W'(sq_dx) + RAD_W'(sq_dr);
      rad[2] <= RAD_W'(sq_dx) + RAD_W'(sq_dlm);
      rad[3] <= RAD_W'(sq_dx) + RAD_W'(sq_drm);
      d3     <= d2;
    end
  end

  logic [ROOT_W-1:0] root [4];

  for (genvar i = 0; i < 4; i++) begin : g_sqrt
    hvd_sqrt #(.RAD_W(RAD_W)) u_sqrt (
      .clk  (clk),
      .en   (en),
      .rad  (rad[i]),
      .root (root[i])
    );
  end

  hvd_delay #(.WIDTH($bits(diffs_t)), .DEPTH(ROOT_W)) u_dly_diff (
    .clk (clk),
    .en  (en),
    .d   (d3),
    .q   (d4)
  );

  // Stage 4: guarded distances and the operands of the eight ratios.
  logic [ROOT_W-1:0] rnum [8];
  logic [ROOT_W-1:0] rden [8];
  side_t             side4, side5;

  always_ff @(posedge clk) begin
    if (en) begin
      rnum[0] <= ROOT_W'(mag_of(d4.dl));
      rnum[1] <= ROOT_W'(mag_of(d4.dr));
      rnum[2] <= ROOT_W'(mag_of(d4.dx));
      rnum[3] <= ROOT_W'(mag_of(d4.dx));
      rnum[4] <= ROOT_W'(mag_of(d4.dlm));
      rnum[5] <= ROOT_W'(mag_of(d4.drm));
      rnum[6] <= ROOT_W'(mag_of(d4.dx));
      rnum[7] <= ROOT_W'(mag_of(d4.dx));
      rden[0] <= root[0] + 1'b1;
      rden[1] <= root[1] + 1'b1;
      rden[2] <= root[1] + 1'b1;
      rden[3] <= root[0] + 1'b1;
      rden[4] <= root[2] + 1'b1;
      rden[5] <= root[3] + 1'b1;
      rden[6] <= root[3] + 1'b1;
      rden[7] <= root[2] + 1'b1;
      side4.neg_dx  <= d4.dx[DIFF_W-1];
      side4.neg_dl  <= d4.dl[DIFF_W-1];
      side4.neg_dr  <= d4.dr[DIFF_W-1];
      side4.neg_dlm <= d4.dlm[DIFF_W-1];
      side4.neg_drm <= d4.drm[DIFF_W-1];
      side4.mag_dx  <= mag_of(d4.dx);
      side4.mag_dl  <= mag_of(d4.dl);
      side4.mag_dr  <= mag_of(d4.dr);
      side4.mag_dlm <= mag_of(d4.dlm);
      side4.mag_drm <= mag_of(d4.drm);
    end
  end

  logic [RATIO_W-1:0] rq [8];

  for (genvar i = 0; i < 8; i++) begin : g_ratio
    hvd_div #(.DS_W(ROOT_W), .Q_W(RATIO_W)) u_div (
      .clk    (clk),
      .en     (en),
      .rem_in (rnum[i]),
      .dvd_in ('0),
      .den_in (rden[i]),
      .quo    (rq[i])
    );
  end

  hvd_delay #(.WIDTH($bits(side_t)), .DEPTH(RATIO_W)) u_dly_side (
    .clk (clk),
    .en  (en),
    .d   (side4),
    .q   (side5)
  );

  // Stage 5: signed ratios combine into the six numerators.
  logic signed [RATIO_W:0]   sr [8];
  logic [7:0]                rneg;
  logic signed [RATIO_W+1:0] num [6];
  logic [5:0]                den_neg;
  mag_t                      den_mag5 [6];
  logic [NUM_W-1:0]          nmag5 [6];
  term_flag_t                flag5, flag6, flag7;
  mag_t                      den_mag6 [6];

  assign rneg = {side5.neg_dx, side5.neg_dx, side5.neg_drm, side5.neg_dlm,
                 side5.neg_dx, side5.neg_dx, side5.neg_dr, side5.neg_dl};
  assign den_neg = {side5.neg_dlm, side5.neg_drm, side5.neg_dx,
                    side5.neg_dl, side5.neg_dr, side5.neg_dx};
  assign den_mag5[0] = side5.mag_dx;
  assign den_mag5[1] = side5.mag_dr;
  assign den_mag5[2] = side5.mag_dl;
  assign den_mag5[3] = side5.mag_dx;
  assign den_mag5[4] = side5.mag_drm;
  assign den_mag5[5] = side5.mag_dlm;

  for (genvar i = 0; i < 8; i++) begin : g_sr
    assign sr[i] = rneg[i] ? -$signed({1'b0, rq[i]}) : $signed({1'b0, rq[i]});
  end

  for (genvar h = 0; h < 2; h++) begin : g_num
    // Bound segment takes the difference of the edge ratios; each trailing
    // leg takes one plus its chordwise ratio.
    assign num[3*h]   = (RATIO_W+2)'(sr[4*h+1]) - (RATIO_W+2)'(sr[4*h]);
    assign num[3*h+1] = $signed({1'b0, ONE_Q30}) + (RATIO_W+2)'(sr[4*h+2]);
    assign num[3*h+2] = $signed({1'b0, ONE_Q30}) + (RATIO_W+2)'(sr[4*h+3]);
  end

  for (genvar i = 0; i < 6; i++) begin : g_s5
    always_ff @(posedge clk) begin
      if (en) begin
        nmag5[i]      <= num[i][RATIO_W+1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
        flag5.neg[i]  <= num[i][RATIO_W+1] ^ den_neg[i];
        flag5.zero[i] <= den_mag5[i] == '0;
        den_mag6[i]   <= den_mag5[i];
      end
    end
  end

  // Stage 6: scale by 1 / (4 pi) and drop to output units.
  logic [PW-1:0]       pterm [6];
  logic [PW+SHIFT-1:0] prod [6];
  mag_t                den_mag7 [6];

  for (genvar i = 0; i < 6; i++) begin : g_s6
    assign prod[i] = nmag5[i] * INV_4PI;
    always_ff @(posedge clk) begin
      if (en) begin
        pterm[i]    <= prod[i][PW+SHIFT-1:SHIFT];
        den_mag7[i] <= den_mag6[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag6 <= flag5;
    end
  end

  logic [PW-1:0] tq [6];

  for (genvar i = 0; i < 6; i++) begin : g_term
    hvd_div #(.DS_W(DIFF_W), .Q_W(PW)) u_div (
      .clk    (clk),
      .en     (en),
      .rem_in ('0),
      .dvd_in (pterm[i]),
      .den_in (den_mag7[i]),
      .quo    (tq[i])
    );
  end

  hvd_delay #(.WIDTH($bits(term_flag_t)), .DEPTH(PW)) u_dly_flag (
    .clk (clk),
    .en  (en),
    .d   (flag6),
    .q   (flag7)
  );

  // Stage 7: signed terms, a zero denominator skips its term.
  logic signed [SW-1:0] tv [6];
  logic signed [SW-1:0] w_main, w_mirr;

  for (genvar i = 0; i < 6; i++) begin : g_tv
    assign tv[i] = flag7.zero[i] ? '0 :
                   flag7.neg[i]  ? -$signed(SW'(tq[i])) : $signed(SW'(tq[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_main <= tv[0] + tv[1] - tv[2];
      w_mirr <= tv[3] + tv[4] - tv[5];
    end
  end

  // Stage 8: symmetric sum and saturation into the output register.
  logic signed [EW-1:0] e_main, e_sum;
  logic [31:0]          o_main, o_sum;

  assign e_main = EW'(w_main);
  assign e_sum  = EW'(w_main) + EW'(w_mirr);
  assign o_main = (e_main > SAT_HI) ? 32'h7fffffff :
                  (e_main < SAT_LO) ? 32'h80000000 : e_main[31:0];
  assign o_sum  = (e_sum > SAT_HI) ? 32'h7fffffff :
                  (e_sum < SAT_LO) ? 32'h80000000 : e_sum[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {o_sum, o_main};
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("waiting result changed or dropped");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
      !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused without an output stall");

endmodule

// ===== sim/tb_horseshoe_vortex_downwash_top.sv =====
// ----------------------------------------------------------------------------
// Horseshoe vortex downwash testbench
// Drives collocation points and horseshoe geometries into the pipeline and
// compares both downwash values with an in-bench integer predictor, under
// random idling on both stream sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_horseshoe_vortex_downwash_top;
  import hvd_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int TERM_SHIFT = 62 - 2 * FRAC_BITS;
  localparam int LATENCY    = 73 + (2 * FRAC_BITS - 2);
  localparam int CYCLE_CAP  = 600000;
  localparam logic [63:0] RECIP_4PI = 64'd341782638;
  localparam longint UNIT_Q30 = 64'sd1 << 30;
  localparam logic [31:0] MAX32 = 32'h7fffffff;
  localparam logic [31:0] MIN32 = 32'h80000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;

  logic [63:0] pending_results[$];
  int unsigned errors   = 0;
  int unsigned sent     = 0;
  int unsigned received = 0;
  int unsigned cycles   = 0;
  bit          idle_on   = 1'b1;
  bit          long_hold = 1'b0;

  horseshoe_vortex_downwash_top #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // floor(sqrt(a^2 + b^2)) + 1, one root bit at a time.
  function automatic logic [63:0] guarded_radius(longint a, longint b);
    logic [127:0] sum;
    logic [63:0]  root;
    logic [63:0]  trial;
    root = '0;
    sum = 128'(abs64(a)) * 128'(abs64(a)) + 128'(abs64(b)) * 128'(abs64(b));
    for (int i = 34; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (128'(trial) * 128'(trial) <= sum) root = trial;
    end
    return root + 64'd1;
  endfunction

  function automatic longint ratio_q30(longint n, logic [63:0] r);
    logic [63:0] q;
    q = (abs64(n) << 30) / r;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint biot_term(longint num, longint den);
    logic [63:0] p;
    logic [63:0] q;
    p = (abs64(num) * RECIP_4PI) >> TERM_SHIFT;
    q = p / abs64(den);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint horseshoe_w(longint px, longint py, longint bx,
                                         longint yl, longint yr);
    longint dx, dl, dr, w;
    logic [63:0] r1, r2;
    dx = px - bx;
    dl = py - yl;
    dr = py - yr;
    r1 = guarded_radius(dx, dl);
    r2 = guarded_radius(dx, dr);
    w = 0;
    // A term with a zero denominator difference contributes nothing.
    if (dx != 0) w += biot_term(-(ratio_q30(dl, r1) - ratio_q30(dr, r2)), dx);
    if (dr != 0) w += biot_term(UNIT_Q30 + ratio_q30(dx, r2), dr);
    if (dl != 0) w -= biot_term(UNIT_Q30 + ratio_q30(dx, r1), dl);
    return w;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return MAX32;
    if (v < -64'sd2147483648) return MIN32;
    return v[31:0];
  endfunction

  function automatic logic [63:0] predict_downwash(logic [159:0] d);
    longint px, py, bx, yl, yr, w_main, w_mirror;
    px = longint'(signed'(d[31:0]));
    py = longint'(signed'(d[63:32]));
    bx = longint'(signed'(d[95:64]));
    yl = longint'(signed'(d[127:96]));
    yr = longint'(signed'(d[159:128]));
    w_main = horseshoe_w(px, py, bx, yl, yr);
    // Mirror edges are negated at full width, so the most negative value is safe.
    w_mirror = horseshoe_w(px, py, bx, -yr, -yl);
    return {clamp32(w_main + w_mirror), clamp32(w_main)};
  endfunction

  task automatic send_geometry(logic [31:0] px, logic [31:0] py, logic [31:0] bx,
                               logic [31:0] yl, logic [31:0] yr);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {yr, yl, bx, py, px};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_downwash({yr, yl, bx, py, px}));
    sent++;
  endtask

  // Receiver: random gaps per transaction, plus one long hold-off on request.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (500) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && !long_hold);
    end
  end

  always @(posedge clk) begin
    logic [63:0] exp_r;
    if (!rst && m_tvalid && m_tready) begin
      received <= received + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[31:0] !== exp_r[31:0]) begin
          $display("%0t: downwash expected %h actual %h", $time, exp_r[31:0], m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] !== exp_r[63:32]) begin
          $display("%0t: symmetric_downwash expected %h actual %h",
                   $time, exp_r[63:32], m_tdata[63:32]);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_coord(int mode);
    case (mode)
      0: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return MAX32;
          1: return MIN32;
          2: return 32'd0;
          3: return 32'd1;
          4: return 32'hffffffff;
          default: return 32'($signed($urandom_range(0, 64)) - 32);
        endcase
      end
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] one_q;
    one_q = 32'h00010000;
    send_geometry(0, 0, 0, 0, 0);
    send_geometry(MAX32, MAX32, MAX32, MAX32, MAX32);
    send_geometry(MIN32, MIN32, MIN32, MIN32, MIN32);
    send_geometry(MAX32, MIN32, MIN32, MAX32, MIN32);
    send_geometry(MIN32, MAX32, MAX32, MIN32, MAX32);
    send_geometry(MAX32, 0, MIN32, MIN32, MAX32);
    send_geometry(one_q, 0, 0, -one_q, one_q);
    send_geometry(2 * one_q, one_q / 2, 0, -one_q, one_q);
    // Point on the bound line, on each trailing leg, and on both at once.
    send_geometry(0, one_q / 4, 0, -one_q, one_q);
    send_geometry(one_q, one_q, 0, -one_q, one_q);
    send_geometry(one_q, -one_q, 0, -one_q, one_q);
    send_geometry(0, one_q, 0, -one_q, one_q);
    // One LSB away from the bound segment: large terms.
    send_geometry(1, 0, 0, -one_q, one_q);
    send_geometry(-1, 0, 0, -one_q, one_q);
    send_geometry(1, 1, 0, 0, 2);
    send_geometry(0, 1, 0, 0, 0);
    // Edge at the most negative value, so its mirror lies beyond the 32-bit range.
    send_geometry(one_q, 0, 0, MIN32, MIN32);
    send_geometry(one_q, 0, 0, MIN32, MAX32);
    send_geometry(-one_q, 3 * one_q, 5 * one_q, one_q, -one_q);
    send_geometry(32'hffffffff, 32'hffffffff, 0, 32'hffffffff, 0);
  endtask

  task automatic test_random(int count);
    int mode;
    int kind;
    logic [31:0] px, py, bx, yl, yr, half;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      mode = kind < 65 ? 0 : (kind < 85 ? 1 : 2);
      bx = pick_coord(mode);
      px = pick_coord(mode);
      yl = pick_coord(mode);
      half = 32'($urandom_range(1, 1 << 19));
      // Mostly well-formed panels: left edge below right edge.
      yr = (mode == 0) ? yl + half : pick_coord(mode);
      py = pick_coord(mode);
      case ($urandom_range(0, 9))
        0: py = yl;
        1: py = yr;
        2: px = bx;
        3: begin px = bx; py = yr; end
        default: ;
      endcase
      send_geometry(px, py, bx, yl, yr);
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    idle_on = 1'b0;
    test_random(300);
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random(200);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(650);
    test_backpressure();
    test_back_to_back();
    test_random(480);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 50) @(posedge clk);
    $display("Sent %0d geometries, checked %0d results, including a long output stall.",
             sent, received);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== horseshoe_vortex_downwash_top.f =====
design/hvd_pkg.sv
design/hvd_delay.sv
design/hvd_sqrt.sv
design/hvd_div.sv
design/horseshoe_vortex_downwash_top.sv
sim/tb_horseshoe_vortex_downwash_top.sv
